/* hw/rtl/bfrs_pkg.sv */
`default_nettype none
package bfrs_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int MAX_CHANNELS = 16;
  localparam int DELAY_DEPTH  = MAX_WINDOW * MAX_CHANNELS;

  localparam int WIN_W   = 7;
  localparam int CHAN_W  = 5;
  localparam int SPAN_W  = $clog2(DELAY_DEPTH + 1);
  localparam int PTR_W   = $clog2(DELAY_DEPTH);
  localparam int CIDX_W  = $clog2(MAX_CHANNELS);
  localparam int SAMPLE_W = 8;
  localparam int SUM_W    = 16;

  localparam logic [WIN_W-1:0]  WINDOW_RESET   = WIN_W'(3);
  localparam logic [CHAN_W-1:0] CHANNELS_RESET = CHAN_W'(1);

  typedef enum logic [0:0] {
    REG_WINDOW_SIZE = 1'b0,
    REG_CHANNELS    = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

/* hw/rtl/box_filter_row_sum_top.sv */
`default_nettype none
// Box filter, horizontal pass: running per-channel sum over a row.
//
// Input stream (s_axis_*): one 8-bit sample per beat, channels of a pixel
// interleaved; tlast marks the last sample of the row. After that beat the
// window, channel counter and all channel sums return to zero.
// Output stream (m_axis_*): one 16-bit sum per input beat once the window
// of that beat's channel is full; tlast repeats the input tlast. A row
// shorter than the window produces no output beats.
// Config channel (cfg_*): index 0 = window_size, 1 = channels. Always
// ready; each write also clears the row state. Write only while idle.
//
// Throughput: one beat per cycle while the receiver does not stall. The
// delay line is a 1024 x 8 RAM read and written at the same address in
// the accept cycle (old data comes out); the sum stage then updates the
// channel sum. If the receiver stalls, a finished result waits in the output
// register, one more item waits in the sum stage, and the input then stops.
// Reset: synchronous, clears the row state and loads window_size = 3 and
// channels = 1; the RAM is not cleared (an entry is read only after it was
// written in the current row).
module box_filter_row_sum_top (
  input  wire                         clk,
  input  wire                         rst,
  // config write channel
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire                         cfg_index,
  input  wire  [6:0]                  cfg_data,
  // input stream
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire  [7:0]                  s_axis_tdata,   // [7:0] sample
  input  wire                         s_axis_tlast,   // last_in_row
  // output stream
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  output logic [15:0]                 m_axis_tdata,   // [15:0] window_sum
  output logic                        m_axis_tlast    // last_out
);
  import bfrs_pkg::*;

  // config registers
  logic [WIN_W-1:0]  window_size;
  logic [CHAN_W-1:0] channels;
  logic [WIN_W-1:0]  eff_win;
  logic [CHAN_W-1:0] eff_chan;
  logic [SPAN_W-1:0] span;
  logic              cfg_wr;

  // row state, accept stage
  logic [SPAN_W-1:0] fill_count;
  logic [CIDX_W-1:0] channel_index;
  logic [PTR_W-1:0]  wr_ptr;

  logic [CIDX_W-1:0] chan_cur;
  logic [CIDX_W:0]   chan_inc;
  logic [PTR_W-1:0]  ptr_cur;
  logic [SPAN_W-1:0] ptr_inc;
  logic              win_full;
  logic              emit;

  // delay line RAM
  logic [SAMPLE_W-1:0] delay_line [DELAY_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;

  // sum stage
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [CIDX_W-1:0]   s1_chan;
  logic                s1_full;
  logic                s1_emit;
  logic                s1_last;
  logic [SUM_W-1:0]    channel_sums [MAX_CHANNELS];
  logic [SUM_W-1:0]    sum_new;

  logic out_free;
  logic s1_move;
  logic in_acc;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  // clamp out-of-range settings
  always_comb begin
    if (window_size == '0) begin
      eff_win = WIN_W'(1);
    end else if (window_size > WIN_W'(MAX_WINDOW)) begin
      eff_win = WIN_W'(MAX_WINDOW);
    end else begin
      eff_win = window_size;
    end
    if (channels == '0) begin
      eff_chan = CHAN_W'(1);
    end else if (channels > CHAN_W'(MAX_CHANNELS)) begin
      eff_chan = CHAN_W'(MAX_CHANNELS);
    end else begin
      eff_chan = channels;
    end
  end

  assign span = SPAN_W'({{(SPAN_W-WIN_W){1'b0}}, eff_win} * {{(SPAN_W-CHAN_W){1'b0}}, eff_chan});

  // handshake
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_move       = s1_valid && (!s1_emit || out_free);
  assign s_axis_tready = !s1_valid || s1_move;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // accept-stage arithmetic
  always_comb begin
    chan_cur = ({1'b0, channel_index} >= eff_chan) ? '0 : channel_index;
    ptr_cur  = ({1'b0, wr_ptr} >= span) ? '0 : wr_ptr;
    chan_inc = {1'b0, chan_cur} + 1'b1;
    ptr_inc  = {1'b0, ptr_cur} + 1'b1;
    win_full = fill_count >= span;
    emit     = ({1'b0, fill_count} + (SPAN_W+1)'(eff_chan)) >= {1'b0, span};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WINDOW_RESET;
      channels      <= CHANNELS_RESET;
      fill_count    <= '0;
      channel_index <= '0;
      wr_ptr        <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_SIZE: window_size <= cfg_data;
        REG_CHANNELS:    channels    <= cfg_data[CHAN_W-1:0];
        default:         ;
      endcase
      fill_count    <= '0;
      channel_index <= '0;
      wr_ptr        <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        fill_count    <= '0;
        channel_index <= '0;
        wr_ptr        <= '0;
      end else begin
        if (!win_full) begin
          fill_count <= fill_count + 1'b1;
        end
        channel_index <= (chan_inc >= eff_chan) ? '0 : chan_inc[CIDX_W-1:0];
        wr_ptr        <= (ptr_inc >= span) ? '0 : ptr_inc[PTR_W-1:0];
      end
    end
  end

  // RAM: read-before-write on the same entry gives the sample leaving the window
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data            <= delay_line[ptr_cur];
      delay_line[ptr_cur] <= s_axis_tdata;
    end
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample <= s_axis_tdata;
      s1_chan   <= chan_cur;
      s1_full   <= win_full;
      s1_emit   <= emit;
      s1_last   <= s_axis_tlast;
    end
  end

  assign sum_new = channel_sums[s1_chan]
                 - (s1_full ? {{(SUM_W-SAMPLE_W){1'b0}}, rd_data} : '0)
                 + {{(SUM_W-SAMPLE_W){1'b0}}, s1_sample};

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        channel_sums[i] <= '0;
      end
    end else if (s1_move) begin
      if (s1_last) begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          channel_sums[i] <= '0;
        end
      end else begin
        channel_sums[s1_chan] <= sum_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_move && s1_emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_emit) begin
      m_axis_tdata <= sum_new;
      m_axis_tlast <= s1_last;
    end
  end

endmodule
`default_nettype wire
